>>> rtl/mfpe_pkg.sv
// Shared types and constants of the monochrome framebuffer pixel engine.
package mfpe_pkg;

   localparam int DEF_COLUMNS = 128;
   localparam int DEF_PAGES   = 8;

   // Queue between the front and back parts; kept at a power of two.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam int RECIP_SHIFT = 16;

   typedef enum logic [2:0] {
      MODE_SET        = 3'd0,
      MODE_CLEAR      = 3'd1,
      MODE_TOGGLE     = 3'd2,
      MODE_READ_PIXEL = 3'd3,
      MODE_READ_BYTE  = 3'd4,
      MODE_SCROLL     = 3'd5,
      MODE_CLEAR_ALL  = 3'd6
   } mode_type;

   // Classified command as held in the queue.
   typedef struct packed {
      mode_type     mode;
      logic [7:0]   col;
      logic [3:0]   page;
      logic [2:0]   row_bit;
      logic [9:0]   byte_index;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_UPDATE,
      ST_RESPOND,
      ST_SCROLL,
      ST_SCROLL_END,
      ST_CLEAR
   } state_type;

endpackage

>>> rtl/mono_framebuffer_pixel_engine_top.sv
// Top level of the monochrome page framebuffer pixel engine.
//
//   port group  direction  tdata / tuser contents (lowest bit first)
//   req_*       in         tuser: mode[2:0]; tdata: pixel_x[7:0], pixel_y[15:8],
//                          byte_index[25:16], zero [31:26]
//   rsp_*       out        tdata: pixel_value[0], byte_value[8:1], zero [15:9]
//
// Pixel and read words pass through the back part as a store read, then
// write-back and result; the sequencer starts the next word while finishing
// one, so up to one such word completes per cycle while the result register
// is free, set by the single store write port. Scroll and clear all move one
// store byte per cycle. After reset the store is zeroed in a pass over all
// COLUMNS*PAGES bytes (1024 by default) with req_tready low. The result
// register lets the front keep accepting while a result waits for rsp_tready.
module mono_framebuffer_pixel_engine_top
   import mfpe_pkg::*;
#(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int PAGES   = DEF_PAGES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // pixel_x, pixel_y, byte_index, padding
   input  logic [2:0]  req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // pixel_value, byte_value, padding
);

   logic       init_busy;
   logic       q_full, q_empty;
   logic       push, pop;
   cmd_type    push_cmd, head;
   logic       pixel_value;
   logic [7:0] byte_value;

   mfpe_front #(
      .COLUMNS (COLUMNS),
      .PAGES   (PAGES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .mode       (mode_type'(req_tuser)),
      .pixel_x    (req_tdata[7:0]),
      .pixel_y    (req_tdata[15:8]),
      .byte_index (req_tdata[25:16]),
      .init_busy  (init_busy),
      .q_full     (q_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   mfpe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .q_full   (q_full),
      .pop      (pop),
      .q_empty  (q_empty),
      .head     (head)
   );

   mfpe_back #(
      .COLUMNS (COLUMNS),
      .PAGES   (PAGES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .head        (head),
      .pop         (pop),
      .init_busy   (init_busy),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .pixel_value (pixel_value),
      .byte_value  (byte_value)
   );

   assign rsp_tdata = {7'd0, byte_value, pixel_value};

endmodule

>>> rtl/mfpe_front.sv
// Front part: accepts input words and reduces the coordinates to column, page and bit.
module mfpe_front
   import mfpe_pkg::*;
#(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int PAGES   = DEF_PAGES
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  mode_type   mode,
   input  logic [7:0] pixel_x,
   input  logic [7:0] pixel_y,
   input  logic [9:0] byte_index,
   input  logic       init_busy,
   input  logic       q_full,
   output logic       push,
   output cmd_type    push_cmd
);

   localparam logic [16:0] X_RECIP = 17'((1 << RECIP_SHIFT) / COLUMNS);
   localparam logic [16:0] P_RECIP = 17'((1 << RECIP_SHIFT) / PAGES);

   logic       a_valid_ff, a_valid_in;
   mode_type   a_mode_ff;
   logic [7:0] a_x_ff;
   logic [4:0] a_yp_ff;
   logic [2:0] a_row_ff;
   logic [9:0] a_idx_ff;
   logic [7:0] a_qx_ff;
   logic [4:0] a_qp_ff;

   logic        accept;
   logic [24:0] x_prod;
   logic [21:0] p_prod;
   logic [16:0] qcx;
   logic [9:0]  qcp;
   logic [8:0]  rx_raw, rx;
   logic [4:0]  rp_raw, rp;

   assign req_tready = !init_busy && (!a_valid_ff || !q_full);
   assign accept     = req_tvalid && req_tready;
   assign push       = a_valid_ff && !q_full;

   // The quotient estimate by reciprocal is low by at most one; the second
   // stage corrects it with a single compare and subtract.
   assign x_prod = 25'(pixel_x) * 25'(X_RECIP);
   assign p_prod = 22'(pixel_y[7:3]) * 22'(P_RECIP);

   always_comb begin
      a_valid_in = a_valid_ff;
      if (accept) begin
         a_valid_in = 1'b1;
      end else if (push) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_mode_ff <= mode;
         a_x_ff    <= pixel_x;
         a_yp_ff   <= pixel_y[7:3];
         a_row_ff  <= pixel_y[2:0];
         a_idx_ff  <= byte_index;
         a_qx_ff   <= x_prod[23:16];
         a_qp_ff   <= p_prod[20:16];
      end
   end

   always_comb begin
      qcx    = 17'(a_qx_ff) * 17'(COLUMNS);
      rx_raw = {1'b0, a_x_ff} - qcx[8:0];
      rx     = (rx_raw >= 9'(COLUMNS)) ? rx_raw - 9'(COLUMNS) : rx_raw;
      qcp    = 10'(a_qp_ff) * 10'(PAGES);
      rp_raw = a_yp_ff - qcp[4:0];
      rp     = (rp_raw >= 5'(PAGES)) ? rp_raw - 5'(PAGES) : rp_raw;
   end

   always_comb begin
      push_cmd.mode       = a_mode_ff;
      push_cmd.col        = rx[7:0];
      push_cmd.page       = rp[3:0];
      push_cmd.row_bit    = a_row_ff;
      push_cmd.byte_index = a_idx_ff;
   end

endmodule

>>> rtl/mfpe_queue.sv
// Short command queue between the front and back parts.
module mfpe_queue
   import mfpe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    q_full,
   input  logic    pop,
   output logic    q_empty,
   output cmd_type head
);

   cmd_type           slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign q_full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign q_empty = (count_ff == '0);
   assign head    = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/mfpe_back.sv
// Back part: frame store, command sequencer and result register.
module mfpe_back
   import mfpe_pkg::*;
#(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int PAGES   = DEF_PAGES
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  cmd_type    head,
   output logic       pop,
   output logic       init_busy,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic       pixel_value,
   output logic [7:0] byte_value
);

   localparam int DEPTH       = COLUMNS * PAGES;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int SCROLL_SPAN = DEPTH - COLUMNS;
   localparam int WIDE_W      = 13;

   logic [7:0] mem [DEPTH];

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  cnt_ff, cnt_in;
   mode_type           mode_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [7:0]         mask_ff;
   logic               idx_ok_ff;
   logic               prev_ok_ff, prev_ok_in;
   logic [7:0]         rd_data_ff;
   logic               rsp_valid_ff;
   logic               rsp_pixel_ff;
   logic [7:0]         rsp_byte_ff;

   logic              out_free, finish, launch, last;
   state_type         launch_state;
   logic [ADDR_W-1:0] launch_addr;
   logic              launch_idx_ok;
   logic [WIDE_W-1:0] pix_addr_wide;
   logic [ADDR_W:0]   scroll_raddr;
   logic              scroll_in_range;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [7:0]        mem_wdata;
   logic [7:0]        modified;
   logic              res_pixel;
   logic [7:0]        res_byte;

   assign init_busy   = (state_ff == ST_INIT);
   assign rsp_tvalid  = rsp_valid_ff;
   assign pixel_value = rsp_pixel_ff;
   assign byte_value  = rsp_byte_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign last     = (cnt_ff == ADDR_W'(DEPTH - 1));
   assign finish   = out_free && (state_ff == ST_UPDATE || state_ff == ST_RESPOND);
   assign launch   = !q_empty && (state_ff == ST_IDLE || finish);
   assign pop      = launch;

   // Decoding of the queue head for a launch.
   always_comb begin
      pix_addr_wide = WIDE_W'(head.page) * WIDE_W'(COLUMNS) + WIDE_W'(head.col);
      launch_idx_ok = (WIDE_W'(head.byte_index) < WIDE_W'(DEPTH));
      if (head.mode == MODE_READ_BYTE) begin
         launch_addr = ADDR_W'(head.byte_index);
      end else begin
         launch_addr = pix_addr_wide[ADDR_W-1:0];
      end
      unique case (head.mode)
         MODE_SCROLL:    launch_state = ST_SCROLL;
         MODE_CLEAR_ALL: launch_state = ST_CLEAR;
         default:        launch_state = ST_UPDATE;
      endcase
   end

   assign scroll_raddr    = {1'b0, cnt_ff} + (ADDR_W+1)'(COLUMNS);
   assign scroll_in_range = ({1'b0, cnt_ff} < (ADDR_W+1)'(SCROLL_SPAN));

   always_comb begin
      case (mode_ff)
         MODE_SET:    modified = rd_data_ff | mask_ff;
         MODE_CLEAR:  modified = rd_data_ff & ~mask_ff;
         default:     modified = rd_data_ff ^ mask_ff;
      endcase
      res_pixel = (mode_ff == MODE_READ_PIXEL) && ((rd_data_ff & mask_ff) != 8'd0);
      res_byte  = ((mode_ff == MODE_READ_BYTE) && idx_ok_ff) ? rd_data_ff : 8'd0;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (launch) begin
               state_in = launch_state;
            end
         end
         ST_UPDATE, ST_RESPOND: begin
            if (!out_free) begin
               state_in = ST_RESPOND;
            end else if (launch) begin
               state_in = launch_state;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCROLL: begin
            if (last) begin
               state_in = ST_SCROLL_END;
            end
         end
         ST_SCROLL_END: begin
            state_in = ST_RESPOND;
         end
         ST_CLEAR: begin
            if (last) begin
               state_in = ST_RESPOND;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Memory port control and counters.
   always_comb begin
      mem_we     = 1'b0;
      mem_waddr  = cnt_ff;
      mem_wdata  = 8'd0;
      mem_re     = 1'b0;
      mem_raddr  = launch_addr;
      cnt_in     = cnt_ff;
      prev_ok_in = prev_ok_ff;
      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            mem_we = 1'b1;
            if (!last) begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_UPDATE: begin
            mem_we    = (mode_ff == MODE_SET) || (mode_ff == MODE_CLEAR) ||
                        (mode_ff == MODE_TOGGLE);
            mem_waddr = addr_ff;
            mem_wdata = modified;
         end
         ST_SCROLL: begin
            // Each cycle reads the byte one page below, while in range, and writes the one
            // fetched in the previous cycle (zero past the range) one address behind.
            mem_we     = (cnt_ff != '0);
            mem_waddr  = cnt_ff - 1'b1;
            mem_wdata  = prev_ok_ff ? rd_data_ff : 8'd0;
            mem_re     = scroll_in_range;
            mem_raddr  = scroll_raddr[ADDR_W-1:0];
            prev_ok_in = scroll_in_range;
            if (!last) begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SCROLL_END: begin
            mem_we    = 1'b1;
            mem_wdata = prev_ok_ff ? rd_data_ff : 8'd0;
         end
         default: begin
         end
      endcase
      if (launch) begin
         mem_re = 1'b1;
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_INIT;
         cnt_ff     <= '0;
         prev_ok_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         prev_ok_ff <= prev_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (launch) begin
         mode_ff   <= head.mode;
         addr_ff   <= launch_addr;
         mask_ff   <= 8'd1 << head.row_bit;
         idx_ok_ff <= launch_idx_ok;
      end
   end

   // A read of the byte being written in the same cycle returns the new byte.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         if (mem_we && (mem_waddr == mem_raddr)) begin
            rd_data_ff <= mem_wdata;
         end else begin
            rd_data_ff <= mem[mem_raddr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_pixel_ff <= res_pixel;
         rsp_byte_ff  <= res_byte;
      end
   end

endmodule

>>> rtl/mfpe_checker.sv
// Port-level checks of the pixel engine, bound to its top level.
module mfpe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   logic [3:0] outstanding_ff, outstanding_in;
   logic       req_acc, rsp_acc;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_acc && !rsp_acc) begin
         outstanding_in = outstanding_ff + 1'b1;
      end else if (rsp_acc && !req_acc) begin
         outstanding_in = outstanding_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   // A stalled result word holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // No result word without an accepted input word behind it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> outstanding_ff != 4'd0)
      else $error("result word without a pending input word");

   // Words in flight never exceed the storage of the pipeline.
   assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= 4'd5)
      else $error("too many words in flight");

   // The input is closed as the store clearing pass after reset begins.
   assert property (@(posedge clock)
      $past(reset) && !reset |-> !req_tready)
      else $error("input open during the clearing pass");

   // Only one of the two result fields can be non-zero, and padding is zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:9] == 7'd0 && !(rsp_tdata[0] && rsp_tdata[8:1] != 8'd0))
      else $error("malformed result word");

endmodule

bind mono_framebuffer_pixel_engine_top mfpe_checker u_mfpe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> tb/tb_mono_framebuffer_pixel_engine_top.sv
// Self-checking testbench for the monochrome framebuffer pixel engine, with a shadow image.
module tb_mono_framebuffer_pixel_engine_top;
   import mfpe_pkg::*;

   localparam int FB_COLUMNS = DEF_COLUMNS;
   localparam int FB_PAGES   = DEF_PAGES;
   localparam int FB_ROWS    = FB_PAGES * 8;
   localparam int FB_BYTES   = FB_COLUMNS * FB_PAGES;

   // Mode code that the block leaves unused.
   localparam logic [2:0] MODE_UNUSED = 3'd7;

   localparam int RANDOM_WORDS     = 1150;
   localparam int SINK_HOLD_CYCLES = 400;
   localparam int RUN_LIMIT        = 5_000_000;

   typedef struct packed {
      logic       pixel_value;
      logic [7:0] byte_value;
   } readback_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // pixel_x, pixel_y, byte_index, padding
   logic [2:0]  req_tuser = '0;   // mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // pixel_value, byte_value, padding

   logic [7:0]   shadow_fb [FB_BYTES];
   readback_type readback_q [$];
   logic [7:0]   touched_x [$];
   logic [7:0]   touched_y [$];

   int  mismatches = 0;
   bit  tx_idle_en = 1'b1;
   bit  rx_idle_en = 1'b1;
   int  hold_asked = 0;
   int  hold_served = 0;
   int  sink_wait = 0;
   int  cycles;

   mono_framebuffer_pixel_engine_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   // Applies one command to the shadow image and returns the word it should produce.
   function automatic readback_type apply_command(logic [2:0] mode, logic [7:0] px,
                                                  logic [7:0] py, logic [9:0] bidx);
      readback_type r;
      int           col, row, addr, i;
      logic [7:0]   mask;
      r    = '0;
      col  = px % FB_COLUMNS;
      row  = py % FB_ROWS;
      addr = (row / 8) * FB_COLUMNS + col;
      mask = 8'b1 << (row % 8);
      case (mode)
         MODE_SET:        shadow_fb[addr] = shadow_fb[addr] | mask;
         MODE_CLEAR:      shadow_fb[addr] = shadow_fb[addr] & ~mask;
         MODE_TOGGLE:     shadow_fb[addr] = shadow_fb[addr] ^ mask;
         MODE_READ_PIXEL: r.pixel_value = |(shadow_fb[addr] & mask);
         MODE_READ_BYTE: begin
            if (bidx < FB_BYTES) r.byte_value = shadow_fb[bidx];
         end
         MODE_SCROLL: begin
            for (i = 0; i < FB_BYTES - FB_COLUMNS; i++) shadow_fb[i] = shadow_fb[i + FB_COLUMNS];
            for (i = FB_BYTES - FB_COLUMNS; i < FB_BYTES; i++) shadow_fb[i] = '0;
         end
         MODE_CLEAR_ALL: begin
            for (i = 0; i < FB_BYTES; i++) shadow_fb[i] = '0;
         end
         default: ;
      endcase
      return r;
   endfunction

   // Offers one word after a random gap, when idling is enabled, and predicts its result once it is taken.
   task automatic send_word(input logic [2:0] mode, input logic [7:0] px,
                            input logic [7:0] py, input logic [9:0] bidx);
      int gap;
      gap = tx_idle_en ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {6'b0, bidx, py, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      readback_q.push_back(apply_command(mode, px, py, bidx));
      if (mode == MODE_SET || mode == MODE_CLEAR || mode == MODE_TOGGLE) begin
         touched_x.push_back(px);
         touched_y.push_back(py);
         if (touched_x.size() > 16) begin
            void'(touched_x.pop_front());
            void'(touched_y.pop_front());
         end
      end
   endtask

   task automatic send_random_word();
      logic [2:0] mode;
      logic [7:0] px, py;
      logic [9:0] bidx;
      int         pick, k;
      pick = $urandom_range(0, 99);
      if (pick < 24) mode = MODE_SET;
      else if (pick < 34) mode = MODE_CLEAR;
      else if (pick < 46) mode = MODE_TOGGLE;
      else if (pick < 68) mode = MODE_READ_PIXEL;
      else if (pick < 94) mode = MODE_READ_BYTE;
      else if (pick < 96) mode = MODE_SCROLL;
      else if (pick < 97) mode = MODE_CLEAR_ALL;
      else mode = MODE_UNUSED;
      px   = 8'($urandom);
      py   = 8'($urandom);
      bidx = 10'($urandom);
      // Mostly revisit recently written pixels, through any of their wrapped aliases,
      // so that reads find something other than zeros.
      if (touched_x.size() > 0 && $urandom_range(0, 99) < 60) begin
         k    = $urandom_range(0, touched_x.size() - 1);
         px   = {px[7], touched_x[k][6:0]};
         py   = {py[7:6], touched_y[k][5:0]};
         bidx = {touched_y[k][5:3], touched_x[k][6:0]};
      end
      send_word(mode, px, py, bidx);
   endtask

   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      while (readback_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_cases();
      send_word(MODE_READ_BYTE,  8'd0,   8'd0,   10'd0);
      send_word(MODE_READ_BYTE,  8'd0,   8'd0,   10'd1023);
      send_word(MODE_SET,        8'd0,   8'd0,   10'd0);
      send_word(MODE_SET,        8'd127, 8'd63,  10'd0);
      // Wrapped coordinates reach the corner that was just set.
      send_word(MODE_TOGGLE,     8'd255, 8'd255, 10'd0);
      send_word(MODE_READ_PIXEL, 8'd127, 8'd63,  10'd0);
      send_word(MODE_SET,        8'd200, 8'd130, 10'd0);
      send_word(MODE_READ_BYTE,  8'd0,   8'd0,   10'd72);
      send_word(MODE_READ_PIXEL, 8'd72,  8'd66,  10'd0);
      send_word(MODE_CLEAR,      8'd72,  8'd2,   10'd0);
      send_word(MODE_READ_PIXEL, 8'd72,  8'd2,   10'd0);
      send_word(MODE_TOGGLE,     8'd5,   8'd9,   10'd0);
      send_word(MODE_UNUSED,     8'd255, 8'd255, 10'd1023);
      send_word(MODE_READ_BYTE,  8'd0,   8'd0,   10'd133);
      send_word(MODE_SET,        8'd10,  8'd63,  10'd0);
      send_word(MODE_SCROLL,     8'd255, 8'd255, 10'd1023);
      send_word(MODE_READ_BYTE,  8'd0,   8'd0,   10'd5);
      send_word(MODE_READ_BYTE,  8'd0,   8'd0,   10'd778);
      send_word(MODE_READ_BYTE,  8'd255, 8'd255, 10'd906);
      // Unused fields of a pixel read are ignored.
      send_word(MODE_READ_PIXEL, 8'd5,   8'd1,   10'd1023);
      send_word(MODE_CLEAR_ALL,  8'd255, 8'd255, 10'd1023);
      send_word(MODE_READ_BYTE,  8'd0,   8'd0,   10'd778);
      send_word(MODE_READ_BYTE,  8'd255, 8'd255, 10'd1023);
   endtask

   task automatic test_drain_pause();
      repeat (3) begin
         repeat (8) send_random_word();
         pause_until_drained();
      end
   endtask

   task automatic test_output_backpressure();
      tx_idle_en = 1'b0;
      rx_idle_en <= 1'b0;
      hold_asked <= hold_asked + 1;
      repeat (40) send_random_word();
      pause_until_drained();
      tx_idle_en = 1'b1;
   endtask

   task automatic test_random_traffic();
      int i;
      for (i = 0; i < RANDOM_WORDS; i++) begin
         // Some stretches run with no idling on one side or the other.
         if (i % 100 == 0) begin
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en <= ($urandom_range(0, 3) != 0);
         end
         send_random_word();
      end
   endtask

   // Result sink: random stalls, plus a long hold whenever one is asked for.
   always @(posedge clock) begin
      if (hold_asked != hold_served) begin
         hold_served <= hold_asked;
         sink_wait   <= SINK_HOLD_CYCLES;
         rsp_tready  <= 1'b0;
      end else if (sink_wait > 0) begin
         sink_wait  <= sink_wait - 1;
         rsp_tready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 99) < 30) begin
         sink_wait  <= pick_gap();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      readback_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.pixel_value = rsp_tdata[0];
         got.byte_value  = rsp_tdata[8:1];
         if (readback_q.size() == 0) begin
            mismatches++;
            $display("%0t: expected no word, got pixel %0d byte 0x%02h",
                     $time, got.pixel_value, got.byte_value);
         end else begin
            want = readback_q.pop_front();
            if (got.pixel_value !== want.pixel_value) begin
               mismatches++;
               $display("%0t: pixel_value expected %0d, got %0d",
                        $time, want.pixel_value, got.pixel_value);
            end
            if (got.byte_value !== want.byte_value) begin
               mismatches++;
               $display("%0t: byte_value expected 0x%02h, got 0x%02h",
                        $time, want.byte_value, got.byte_value);
            end
         end
      end
   end

   initial begin
      for (cycles = 0; cycles < RUN_LIMIT; cycles++) @(posedge clock);
      $display("** mono_framebuffer_pixel_engine_top: FAILED **");
      $finish;
   end

   initial begin
      for (int i = 0; i < FB_BYTES; i++) shadow_fb[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_drain_pause();
      test_output_backpressure();
      test_random_traffic();
      pause_until_drained();
      // Any stray word after the last one expected is caught by the checker.
      repeat (50) @(posedge clock);
      if (mismatches == 0)
         $display("** mono_framebuffer_pixel_engine_top: PASSED **");
      else
         $display("** mono_framebuffer_pixel_engine_top: FAILED **");
      $finish;
   end

endmodule
